[hw/rtl/idm_pkg.sv]
// ----------------------------------------------------------------------------
// idm_pkg: shared types and constants of the car-following step core
// Saturated fixed-point value type, codes and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package idm_pkg;

  localparam int QW = 41;
  localparam int QB = 39;
  localparam int DW = 34;

  typedef logic signed [QW-1:0] qv_t;

  localparam logic [QB-1:0] LIMIT_MAG = '1;
  localparam qv_t QLIMIT = 41'sh7F_FFFF_FFFF;

  typedef enum logic [2:0] {
    CFG_CRUISE_SPEED   = 3'd0,
    CFG_ACCEL_EXPONENT = 3'd1,
    CFG_MINIMUM_GAP    = 3'd2,
    CFG_HEADWAY_TIME   = 3'd3,
    CFG_MAX_ACCEL      = 3'd4,
    CFG_COMFORT_DECEL  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_STRAIGHT = 2'd0,
    MODE_CROSSING = 2'd1,
    MODE_CHANGE   = 2'd2,
    MODE_GONE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ADV_NONE     = 2'd0,
    ADV_TO_CROSS = 2'd1,
    ADV_TO_LANE  = 2'd2
  } adv_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_MUL,
    SQ_RUN
  } sq_state_e;

  function automatic qv_t sat_q(input logic signed [43:0] x);
    qv_t r;
    if (x > 44'(QLIMIT)) begin
      r = QLIMIT;
    end else if (x < -44'(QLIMIT)) begin
      r = -QLIMIT;
    end else begin
      r = x[QW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/idm_mulq.sv]
// ----------------------------------------------------------------------------
// idm_mulq: pipelined saturating fixed-point multiplier
// Two stages: split partial products, then sum, shift and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_mulq #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  input  wire idm_pkg::qv_t        a_i,
  input  wire idm_pkg::qv_t        b_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     valid_o,
  output idm_pkg::qv_t             p_o,
  output logic [SIDE_W-1:0]        side_o
);

  logic [idm_pkg::QW-1:0] ma, mb;
  logic [39:0] pp_hh_d, pp_hl_d, pp_lh_d, pp_ll_d;
  logic [39:0] pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic        neg_q, v1_q, v2_q;
  logic [SIDE_W-1:0] side1_q, side2_q;
  logic [79:0] sum, shv;
  logic [idm_pkg::QB-1:0] mag;
  idm_pkg::qv_t p_d, p_q;

  always_comb begin
    ma = a_i[idm_pkg::QW-1] ? idm_pkg::QW'(-a_i) : a_i;
    mb = b_i[idm_pkg::QW-1] ? idm_pkg::QW'(-b_i) : b_i;
    pp_hh_d = 40'(ma[39:20]) * 40'(mb[39:20]);
    pp_hl_d = 40'(ma[39:20]) * 40'(mb[19:0]);
    pp_lh_d = 40'(ma[19:0]) * 40'(mb[39:20]);
    pp_ll_d = 40'(ma[19:0]) * 40'(mb[19:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_hh_q <= pp_hh_d;
    pp_hl_q <= pp_hl_d;
    pp_lh_q <= pp_lh_d;
    pp_ll_q <= pp_ll_d;
    neg_q   <= a_i[idm_pkg::QW-1] ^ b_i[idm_pkg::QW-1];
    side1_q <= side_i;
    p_q     <= p_d;
    side2_q <= side1_q;
  end

  always_comb begin
    sum = {pp_hh_q, 40'b0} + {20'b0, pp_hl_q, 20'b0} + {20'b0, pp_lh_q, 20'b0}
        + {40'b0, pp_ll_q};
    shv = sum >> FRAC_BITS;
    mag = (shv > 80'(idm_pkg::LIMIT_MAG)) ? idm_pkg::LIMIT_MAG : shv[idm_pkg::QB-1:0];
    p_d = neg_q ? -idm_pkg::QW'(mag) : idm_pkg::QW'(mag);
  end

  assign valid_o = v2_q;
  assign p_o     = p_q;
  assign side_o  = side2_q;

endmodule

`default_nettype wire

[hw/rtl/idm_divq.sv]
// ----------------------------------------------------------------------------
// idm_divq: pipelined saturating fixed-point divider
// Restoring division, one quotient bit per stage, saturation found up front.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_divq #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_W    = 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      valid_i,
  input  wire idm_pkg::qv_t              a_i,
  input  wire logic [idm_pkg::DW-1:0]    b_i,
  input  wire logic [SIDE_W-1:0]         side_i,
  output logic                           valid_o,
  output idm_pkg::qv_t                   q_o,
  output logic [SIDE_W-1:0]              side_o
);

  localparam int QB = idm_pkg::QB;
  localparam int DW = idm_pkg::DW;

  typedef struct packed {
    logic neg;
    logic azero;
    logic bzero;
    logic sat;
  } flg_t;

  logic [idm_pkg::QW-1:0] ma;
  logic [QB-1:0]          ua;
  logic [DW+QB-1:0]       ub_sh;
  flg_t                   flg_d;

  logic              vld_q  [QB+1];
  logic [DW:0]       rem_q  [QB+1];
  logic [QB-1:0]     low_q  [QB+1];
  logic [QB-1:0]     quo_q  [QB+1];
  logic [DW-1:0]     ub_q   [QB+1];
  flg_t              flg_q  [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];

  logic              vo_q;
  idm_pkg::qv_t      qo_q;
  logic [SIDE_W-1:0] so_q;
  logic [QB-1:0]     mag;
  idm_pkg::qv_t      qo_d;

  always_comb begin
    ma = a_i[idm_pkg::QW-1] ? idm_pkg::QW'(-a_i) : a_i;
    ua = (ma > idm_pkg::QW'(idm_pkg::LIMIT_MAG)) ? idm_pkg::LIMIT_MAG : ma[QB-1:0];
    ub_sh = (DW+QB)'(b_i) << (QB - FRAC_BITS);
    flg_d.neg   = a_i[idm_pkg::QW-1];
    flg_d.azero = (a_i == '0);
    flg_d.bzero = (b_i == '0);
    flg_d.sat   = ((DW+QB)'(ua) >= ub_sh);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= (DW+1)'(ua[QB-1 -: FRAC_BITS]);
    low_q[0]  <= {ua[QB-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
    quo_q[0]  <= '0;
    ub_q[0]   <= b_i;
    flg_q[0]  <= flg_d;
    side_q[0] <= side_i;
  end

  for (genvar k = 0; k < QB; k++) begin : g_iter
    logic [DW:0] sh, rem_n;
    logic        ge;

    always_comb begin
      sh    = {rem_q[k][DW-1:0], low_q[k][QB-1]};
      ge    = (sh >= {1'b0, ub_q[k]});
      rem_n = ge ? (sh - {1'b0, ub_q[k]}) : sh;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_n;
      low_q[k+1]  <= {low_q[k][QB-2:0], 1'b0};
      quo_q[k+1]  <= {quo_q[k][QB-2:0], ge};
      ub_q[k+1]   <= ub_q[k];
      flg_q[k+1]  <= flg_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  always_comb begin
    if (flg_q[QB].bzero) begin
      mag = flg_q[QB].azero ? '0 : idm_pkg::LIMIT_MAG;
    end else if (flg_q[QB].sat) begin
      mag = idm_pkg::LIMIT_MAG;
    end else begin
      mag = quo_q[QB];
    end
    qo_d = flg_q[QB].neg ? -idm_pkg::QW'(mag) : idm_pkg::QW'(mag);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vld_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    qo_q <= qo_d;
    so_q <= side_q[QB];
  end

  assign valid_o = vo_q;
  assign q_o     = qo_q;
  assign side_o  = so_q;

endmodule

`default_nettype wire

[hw/rtl/idm_isqrt.sv]
// ----------------------------------------------------------------------------
// idm_isqrt: sequential integer square root of max_accel * comfort_decel
// A multiply step, then 32 bit-pair iterations; busy while running.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] a_i,
  input  wire logic [30:0] b_i,
  output logic             busy_o,
  output logic [31:0]      root_o
);

  idm_pkg::sq_state_e state_q, state_d;
  logic [63:0] x_q, x_d, r_q, r_d, bit_q, bit_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] root_q, root_d;
  logic [63:0] trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idm_pkg::SQ_MUL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    r_q    <= r_d;
    bit_q  <= bit_d;
    root_q <= root_d;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    r_d     = r_q;
    bit_d   = bit_q;
    root_d  = root_q;
    trial   = r_q + bit_q;
    unique case (state_q)
      idm_pkg::SQ_IDLE: begin
      end
      idm_pkg::SQ_MUL: begin
        x_d     = 64'(a_i) * 64'(b_i);
        r_d     = '0;
        bit_d   = 64'd1 << 62;
        cnt_d   = '0;
        state_d = idm_pkg::SQ_RUN;
      end
      idm_pkg::SQ_RUN: begin
        if (x_q >= trial) begin
          x_d = x_q - trial;
          r_d = (r_q >> 1) + bit_q;
        end else begin
          r_d = r_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == '1) begin
          root_d  = r_d[31:0];
          state_d = idm_pkg::SQ_IDLE;
        end
      end
      default: state_d = idm_pkg::SQ_IDLE;
    endcase
    if (start_i) begin
      state_d = idm_pkg::SQ_MUL;
    end
  end

  assign busy_o = (state_q != idm_pkg::SQ_IDLE);
  assign root_o = root_q;

endmodule

`default_nettype wire

[hw/rtl/idm_car_following_step_core.sv]
// ----------------------------------------------------------------------------
// idm_car_following_step_core: fixed-point IDM car-following step
// Pipeline: two 39-stage divider chains in series and the 15-stage free-term
//   product chain carry each car to the result strobe.
// Throughput: one car per cycle while busy is low; the result stream is never stalled.
// Reset: registers load their reset values; busy stays high while the
//   sqrt(max_accel*comfort_decel) unit runs, and again after each
//   configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

module idm_car_following_step_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [9:0]         step_ms_i,
  input  wire logic [1:0]         car_mode_i,
  input  wire logic signed [31:0] car_pos_i,
  input  wire logic signed [31:0] car_speed_i,
  input  wire logic               has_leader_i,
  input  wire logic signed [31:0] leader_pos_i,
  input  wire logic [30:0]        leader_len_i,
  input  wire logic signed [31:0] leader_speed_i,
  input  wire logic               path_open_i,
  input  wire logic [30:0]        segment_len_i,
  output logic                    result_valid_o,
  output logic signed [31:0]      new_pos_o,
  output logic signed [31:0]      new_speed_o,
  output logic signed [31:0]      accel_out_o,
  output logic [1:0]              advance_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  localparam int NEXP = 15;
  localparam idm_pkg::qv_t ONE = idm_pkg::QW'(1) << FRAC_BITS;

  typedef struct packed {
    logic [9:0]         dt;
    logic [1:0]         mode;
    logic signed [31:0] pos;
    logic signed [31:0] v;
    logic               lead;
    logic               open;
    logic [30:0]        seg;
    logic signed [33:0] gapf;
    logic signed [33:0] gaps;
  } base_t;

  typedef struct packed {
    base_t        b;
    idm_pkg::qv_t m_vh;
  } pb_t;

  typedef struct packed {
    base_t        b;
    idm_pkg::qv_t r;
  } pd_t;

  typedef struct packed {
    base_t        b;
    idm_pkg::qv_t r;
    idm_pkg::qv_t tf;
    idm_pkg::qv_t ts;
    idm_pkg::qv_t t;
  } ch_t;

  typedef struct packed {
    base_t              b;
    logic signed [31:0] acc;
    logic signed [42:0] vdt;
    logic signed [42:0] adt;
  } h1_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] pos;
    logic signed [31:0] v;
    logic               open;
    logic [30:0]        seg;
    logic signed [31:0] acc;
    logic signed [31:0] spd;
    logic signed [43:0] pv;
    logic signed [53:0] adt2;
  } h2_t;

  // configuration
  logic [30:0] cruise_q, gap0_q, headway_q, amax_q, decel_q;
  logic [3:0]  expo_q;
  logic        cfg_wr;
  logic [31:0] root;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q  <= 31'd65536;
      expo_q    <= 4'd4;
      gap0_q    <= 31'd131072;
      headway_q <= 31'd65536000;
      amax_q    <= 31'd65;
      decel_q   <= 31'd98;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        idm_pkg::CFG_CRUISE_SPEED:   cruise_q  <= cfg_data_i[30:0];
        idm_pkg::CFG_ACCEL_EXPONENT: expo_q    <= cfg_data_i[3:0];
        idm_pkg::CFG_MINIMUM_GAP:    gap0_q    <= cfg_data_i[30:0];
        idm_pkg::CFG_HEADWAY_TIME:   headway_q <= cfg_data_i[30:0];
        idm_pkg::CFG_MAX_ACCEL:      amax_q    <= cfg_data_i[30:0];
        idm_pkg::CFG_COMFORT_DECEL:  decel_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  idm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_wr),
    .a_i     (amax_q),
    .b_i     (decel_q),
    .busy_o  (busy),
    .root_o  (root)
  );

  // input stage
  logic               accept;
  logic               s0_v_q;
  base_t              s0_b_q, s0_b_d;
  logic signed [32:0] s0_dvl_q;

  assign accept = start && !busy;

  always_comb begin
    s0_b_d.dt   = step_ms_i;
    s0_b_d.mode = car_mode_i;
    s0_b_d.pos  = car_pos_i;
    s0_b_d.v    = car_speed_i;
    s0_b_d.lead = has_leader_i;
    s0_b_d.open = path_open_i;
    s0_b_d.seg  = segment_len_i;
    s0_b_d.gapf = 34'(leader_pos_i) - $signed(34'(leader_len_i)) - 34'(car_pos_i);
    s0_b_d.gaps = $signed(34'(segment_len_i)) - 34'(car_pos_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else begin
      s0_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_b_q   <= s0_b_d;
    s0_dvl_q <= 33'(car_speed_i) - 33'(leader_speed_i);
  end

  // speed products
  logic         a_v;
  base_t        a_b;
  logic [$bits(base_t)-1:0] a_side;
  idm_pkg::qv_t m_vh, m_vd, m_vv;

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(base_t))) u_mul_vh (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (s0_v_q),
    .a_i (idm_pkg::QW'(s0_b_q.v)), .b_i (idm_pkg::QW'(headway_q)),
    .side_i (s0_b_q), .valid_o (a_v), .p_o (m_vh), .side_o (a_side)
  );

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_vd (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (s0_v_q),
    .a_i (idm_pkg::QW'(s0_b_q.v)), .b_i (idm_pkg::QW'(s0_dvl_q)),
    .side_i (1'b0), .valid_o (), .p_o (m_vd), .side_o ()
  );

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_vv (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (s0_v_q),
    .a_i (idm_pkg::QW'(s0_b_q.v)), .b_i (idm_pkg::QW'(s0_b_q.v)),
    .side_i (1'b0), .valid_o (), .p_o (m_vv), .side_o ()
  );

  assign a_b = base_t'(a_side);

  // first quotients
  pb_t          b_in;
  logic         b_v;
  logic [$bits(pb_t)-1:0] b_side;
  pb_t          b_out;
  idm_pkg::qv_t q_r, q_d1, q_d2;

  assign b_in.b    = a_b;
  assign b_in.m_vh = m_vh;

  idm_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(pb_t))) u_div_r (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (a_v),
    .a_i (idm_pkg::QW'(a_b.v)), .b_i (idm_pkg::DW'(cruise_q)),
    .side_i (b_in), .valid_o (b_v), .q_o (q_r), .side_o (b_side)
  );

  idm_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_f (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (a_v),
    .a_i (m_vd), .b_i (idm_pkg::DW'({root, 1'b0})),
    .side_i (1'b0), .valid_o (), .q_o (q_d1), .side_o ()
  );

  idm_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_s (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (a_v),
    .a_i (m_vv), .b_i (idm_pkg::DW'({decel_q, 1'b0})),
    .side_i (1'b0), .valid_o (), .q_o (q_d2), .side_o ()
  );

  assign b_out = pb_t'(b_side);

  // numerators
  logic         c_v_q;
  pd_t          c_d_q;
  idm_pkg::qv_t numf_q, nums_q, numf_d, nums_d;

  always_comb begin
    numf_d = idm_pkg::sat_q(44'(idm_pkg::sat_q(44'(idm_pkg::QW'(gap0_q)) + 44'(b_out.m_vh)))
                            + 44'(q_d1));
    nums_d = idm_pkg::sat_q(44'(idm_pkg::sat_q(44'(ONE) + 44'(b_out.m_vh))) + 44'(q_d2));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else begin
      c_v_q <= b_v;
    end
  end

  always_ff @(posedge clk_i) begin
    c_d_q.b <= b_out.b;
    c_d_q.r <= q_r;
    numf_q  <= numf_d;
    nums_q  <= nums_d;
  end

  // gap quotients
  logic         d_v;
  logic [$bits(pd_t)-1:0] d_side;
  idm_pkg::qv_t q_gf, q_gs;

  idm_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(pd_t))) u_div_gf (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (c_v_q),
    .a_i (numf_q), .b_i (c_d_q.b.gapf[idm_pkg::DW-1:0]),
    .side_i (c_d_q), .valid_o (d_v), .q_o (q_gf), .side_o (d_side)
  );

  idm_divq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_div_gs (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (c_v_q),
    .a_i (nums_q), .b_i (c_d_q.b.gaps[idm_pkg::DW-1:0]),
    .side_i (1'b0), .valid_o (), .q_o (q_gs), .side_o ()
  );

  // squares
  logic         e_v;
  logic [$bits(pd_t)-1:0] e_side;
  pd_t          e_d;
  idm_pkg::qv_t sq_f, sq_s;

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(pd_t))) u_mul_sf (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (d_v),
    .a_i (q_gf), .b_i (q_gf),
    .side_i (d_side), .valid_o (e_v), .p_o (sq_f), .side_o (e_side)
  );

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W(1)) u_mul_ss (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (d_v),
    .a_i (q_gs), .b_i (q_gs),
    .side_i (1'b0), .valid_o (), .p_o (sq_s), .side_o ()
  );

  assign e_d = pd_t'(e_side);

  // free-term product chain
  ch_t  ch  [NEXP+1];
  logic chv [NEXP+1];

  always_comb begin
    ch[0].b = e_d.b;
    ch[0].r = e_d.r;
    ch[0].t = ONE;
    if (!e_d.b.lead) begin
      ch[0].tf = '0;
    end else if (e_d.b.gapf > 34'sd0) begin
      ch[0].tf = sq_f;
    end else begin
      ch[0].tf = idm_pkg::QLIMIT;
    end
    if (!((e_d.b.mode == idm_pkg::MODE_STRAIGHT || e_d.b.mode == idm_pkg::MODE_CHANGE)
          && !e_d.b.open)) begin
      ch[0].ts = '0;
    end else if (e_d.b.gaps > 34'sd0) begin
      ch[0].ts = sq_s;
    end else begin
      ch[0].ts = idm_pkg::QLIMIT;
    end
    chv[0] = e_v;
  end

  for (genvar i = 0; i < NEXP; i++) begin : g_free
    logic [$bits(ch_t)-1:0] so;
    idm_pkg::qv_t           po;
    ch_t                    cs;
    logic                   vo;

    idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(ch_t))) u_mul_free (
      .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (chv[i]),
      .a_i (ch[i].t), .b_i (ch[i].r),
      .side_i (ch[i]), .valid_o (vo), .p_o (po), .side_o (so)
    );

    always_comb begin
      cs = ch_t'(so);
      if (4'(i) < expo_q) begin
        cs.t = po;
      end
      ch[i+1]  = cs;
      chv[i+1] = vo;
    end
  end

  // acceleration
  logic signed [43:0] f_w;
  idm_pkg::qv_t       f_q;
  logic               g_v;
  logic [$bits(base_t)-1:0] g_side;
  idm_pkg::qv_t       g_p;

  always_comb begin
    f_w = 44'(ONE) - 44'(ch[NEXP].t) - 44'(ch[NEXP].tf) - 44'(ch[NEXP].ts);
    f_q = idm_pkg::QW'(idm_pkg::sat32(64'(f_w)));
  end

  idm_mulq #(.FRAC_BITS(FRAC_BITS), .SIDE_W($bits(base_t))) u_mul_acc (
    .clk_i (clk_i), .rst_ni (rst_ni), .valid_i (chv[NEXP]),
    .a_i (idm_pkg::QW'(amax_q)), .b_i (f_q),
    .side_i (ch[NEXP].b), .valid_o (g_v), .p_o (g_p), .side_o (g_side)
  );

  // integration
  logic               h1_v_q, h2_v_q;
  h1_t                h1_q, h1_d;
  h2_t                h2_q, h2_d;
  logic signed [10:0] dt1_s, dt2_s;

  always_comb begin
    h1_d.b   = base_t'(g_side);
    h1_d.acc = idm_pkg::sat32(64'(g_p));
    dt1_s    = $signed({1'b0, h1_d.b.dt});
    h1_d.vdt = 43'(h1_d.b.v) * 43'(dt1_s);
    h1_d.adt = 43'(h1_d.acc) * 43'(dt1_s);
  end

  always_comb begin
    dt2_s     = $signed({1'b0, h1_q.b.dt});
    h2_d.mode = h1_q.b.mode;
    h2_d.pos  = h1_q.b.pos;
    h2_d.v    = h1_q.b.v;
    h2_d.open = h1_q.b.open;
    h2_d.seg  = h1_q.b.seg;
    h2_d.acc  = h1_q.acc;
    h2_d.spd  = idm_pkg::sat32(64'(h1_q.b.v) + 64'(h1_q.adt));
    h2_d.pv   = 44'(h1_q.b.pos) + 44'(h1_q.vdt);
    h2_d.adt2 = 54'(h1_q.adt) * 54'(dt2_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
    end else begin
      h1_v_q <= g_v;
      h2_v_q <= h1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    h1_q <= h1_d;
    h2_q <= h2_d;
  end

  // hand-over and output
  logic signed [53:0] adj, half;
  logic signed [54:0] p, seg_w;
  logic               res_v_q;
  logic signed [31:0] pos_q, pos_d, spd_q, spd_d, acc_q, acc_d;
  logic [1:0]         adv_q, adv_d;

  always_comb begin
    adj   = h2_q.adt2 + $signed({53'b0, h2_q.adt2[53]});
    half  = adj >>> 1;
    p     = 55'(h2_q.pv) + 55'(half);
    seg_w = $signed(55'(h2_q.seg));
    adv_d = idm_pkg::ADV_NONE;
    if (h2_q.mode == idm_pkg::MODE_STRAIGHT && p >= seg_w && h2_q.open) begin
      p     = p - seg_w;
      adv_d = idm_pkg::ADV_TO_CROSS;
    end else if (h2_q.mode == idm_pkg::MODE_CROSSING && p >= seg_w) begin
      p     = p - seg_w;
      adv_d = idm_pkg::ADV_TO_LANE;
    end
    pos_d = idm_pkg::sat32(64'(p));
    spd_d = h2_q.spd;
    acc_d = h2_q.acc;
    if (h2_q.mode == idm_pkg::MODE_GONE) begin
      pos_d = h2_q.pos;
      spd_d = h2_q.v;
      acc_d = '0;
      adv_d = idm_pkg::ADV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= h2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    spd_q <= spd_d;
    acc_q <= acc_d;
    adv_q <= adv_d;
  end

  assign result_valid_o = res_v_q;
  assign new_pos_o      = pos_q;
  assign new_speed_o    = spd_q;
  assign accel_out_o    = acc_q;
  assign advance_o      = adv_q;

endmodule

`default_nettype wire
